>>> rtl/scc_pkg.sv
package scc_pkg;

  localparam int unsigned MaxRows    = 1024;
  localparam int unsigned MaxEntries = 4096;

  localparam int unsigned KindW  = 2;
  localparam int unsigned RowW   = 10;
  localparam int unsigned ColW   = 10;
  localparam int unsigned ValW   = 64;
  localparam int unsigned PtrW   = 13;
  localparam int unsigned StatW  = 2;
  localparam int unsigned RowsW  = 11;
  localparam int unsigned PtrAw  = $clog2(MaxRows + 1);
  localparam int unsigned SlotAw = $clog2(MaxRows);
  localparam int unsigned EntAw  = $clog2(MaxEntries);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  // item kinds
  localparam logic [KindW-1:0] KindLoad  = 2'd0;
  localparam logic [KindW-1:0] KindRdPtr = 2'd1;
  localparam logic [KindW-1:0] KindRdEnt = 2'd2;
  localparam logic [KindW-1:0] KindClear = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatRange = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumRows   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTranspose = 1'd1;

endpackage

>>> rtl/scc_item_if.sv
interface scc_item_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::KindW-1:0]  kind;
  logic [scc_pkg::RowW-1:0]   row;
  logic [scc_pkg::ColW-1:0]   col;
  logic [scc_pkg::ValW-1:0]   value;
  logic [scc_pkg::PtrW-1:0]   addr;

  modport source (output valid, kind, row, col, value, addr, input ready);
  modport sink   (input valid, kind, row, col, value, addr, output ready);
endinterface

>>> rtl/scc_res_if.sv
interface scc_res_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::PtrW-1:0]   pointer;
  logic [scc_pkg::ColW-1:0]   out_col;
  logic [scc_pkg::ValW-1:0]   out_value;
  logic [scc_pkg::StatW-1:0]  status;

  modport source (output valid, pointer, out_col, out_value, status, input ready);
  modport sink   (input valid, pointer, out_col, out_value, status, output ready);
endinterface

>>> rtl/scc_ram.sv
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/sparse_coo_to_csr_converter.sv
// Sparse COO to CSR converter.
// item_i carries one request per transfer: load an entry (row, col, value),
// read a row pointer word, read a sorted entry (column, value) or clear.
// result_o returns exactly one result per request, with a status code.
// Configuration (num_rows, transpose_mode) is written on cfg_*_i; the user
// writes it only while idle, which the block itself does not enforce.
// Loads and clears answer at the accepting edge; reads answer through the
// registered memory read port. The first read after a load or clear first
// runs the counting sort: it zeroes the count words, counts entries per
// row, sums into the pointer and slot memories and scatters the entries.
// One request is in flight at a time; the next one is taken as soon as the
// output register is free or being drained in the same cycle.
// Reset empties the store, marks it unsorted and sets 1024 rows; the
// memories need no clearing, since reads only reach written words.
// A stalled receiver holds the result in the output register and holds
// off new requests.
module sparse_coo_to_csr_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [scc_pkg::CfgDataW-1:0]    cfg_data_i,
  scc_item_if.sink                        item_i,
  scc_res_if.source                       result_o
);

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StIdle  = 4'd0;
  localparam logic [StW-1:0] StServe = 4'd1;
  localparam logic [StW-1:0] StRdWt  = 4'd2;
  localparam logic [StW-1:0] StZero  = 4'd3;
  localparam logic [StW-1:0] StCntA  = 4'd4;
  localparam logic [StW-1:0] StCntB  = 4'd5;
  localparam logic [StW-1:0] StCntC  = 4'd6;
  localparam logic [StW-1:0] StPreA  = 4'd7;
  localparam logic [StW-1:0] StPreB  = 4'd8;
  localparam logic [StW-1:0] StScA   = 4'd9;
  localparam logic [StW-1:0] StScB   = 4'd10;
  localparam logic [StW-1:0] StScC   = 4'd11;

  localparam int unsigned LdW = scc_pkg::RowW + scc_pkg::ColW + scc_pkg::ValW;
  localparam int unsigned SoW = scc_pkg::ColW + scc_pkg::ValW;
  localparam int unsigned CntW = scc_pkg::EntAw + 1;

  logic [StW-1:0]                 state_q, state_d;
  logic [scc_pkg::RowsW-1:0]      num_rows_q;
  logic                           transpose_q;
  logic [CntW-1:0]                ent_cnt_q, ent_cnt_d;
  logic                           sorted_q, sorted_d;
  logic [scc_pkg::RowsW-1:0]      sorted_rows_q, sorted_rows_d;
  logic [scc_pkg::KindW-1:0]      pkind_q, pkind_d;
  logic [scc_pkg::PtrW-1:0]       paddr_q, paddr_d;
  logic [CntW-1:0]                k_q, k_d;
  logic [scc_pkg::RowsW-1:0]      r_q, r_d;
  logic [scc_pkg::PtrW-1:0]       sum_q, sum_d;
  logic [scc_pkg::PtrAw-1:0]      bidx_q, bidx_d;
  logic [scc_pkg::SlotAw-1:0]     bslot_q, bslot_d;
  logic [SoW-1:0]                 hold_q, hold_d;

  logic                           out_valid_q, out_valid_d;
  logic [scc_pkg::PtrW-1:0]       out_ptr_q, out_ptr_d;
  logic [scc_pkg::ColW-1:0]       out_col_q, out_col_d;
  logic [scc_pkg::ValW-1:0]       out_val_q, out_val_d;
  logic [scc_pkg::StatW-1:0]      out_stat_q, out_stat_d;

  // memory ports
  logic                           ld_we;
  logic [scc_pkg::EntAw-1:0]      ld_waddr, ld_raddr;
  logic [LdW-1:0]                 ld_wdata, ld_rdata;
  logic                           so_we;
  logic [scc_pkg::EntAw-1:0]      so_waddr, so_raddr;
  logic [SoW-1:0]                 so_wdata, so_rdata;
  logic                           pt_we;
  logic [scc_pkg::PtrAw-1:0]      pt_waddr, pt_raddr;
  logic [scc_pkg::PtrW-1:0]       pt_wdata, pt_rdata;
  logic                           ns_we;
  logic [scc_pkg::SlotAw-1:0]     ns_waddr, ns_raddr;
  logic [scc_pkg::PtrW-1:0]       ns_wdata, ns_rdata;

  logic [scc_pkg::RowsW-1:0]      rows_act;
  logic                           take;
  logic [scc_pkg::RowW-1:0]       ld_r, ld_c, st_row;
  logic [scc_pkg::RowW-1:0]       bucket;

  scc_ram #(.Width(LdW), .Depth(scc_pkg::MaxEntries)) u_loaded (
    .clk_i, .we_i(ld_we), .waddr_i(ld_waddr), .wdata_i(ld_wdata),
    .raddr_i(ld_raddr), .rdata_o(ld_rdata)
  );
  scc_ram #(.Width(SoW), .Depth(scc_pkg::MaxEntries)) u_sorted (
    .clk_i, .we_i(so_we), .waddr_i(so_waddr), .wdata_i(so_wdata),
    .raddr_i(so_raddr), .rdata_o(so_rdata)
  );
  scc_ram #(.Width(scc_pkg::PtrW), .Depth(scc_pkg::MaxRows + 1)) u_ptrs (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );
  scc_ram #(.Width(scc_pkg::PtrW), .Depth(scc_pkg::MaxRows)) u_slots (
    .clk_i, .we_i(ns_we), .waddr_i(ns_waddr), .wdata_i(ns_wdata),
    .raddr_i(ns_raddr), .rdata_o(ns_rdata)
  );

  // effective row count
  always_comb begin
    if (num_rows_q == '0) begin
      rows_act = scc_pkg::RowsW'(1);
    end else if (num_rows_q > scc_pkg::RowsW'(scc_pkg::MaxRows)) begin
      rows_act = scc_pkg::RowsW'(scc_pkg::MaxRows);
    end else begin
      rows_act = num_rows_q;
    end
  end

  assign item_i.ready = (state_q == StIdle) && (!out_valid_q || result_o.ready);
  assign take = item_i.valid && item_i.ready;
  assign ld_r = transpose_q ? item_i.col : item_i.row;
  assign ld_c = transpose_q ? item_i.row : item_i.col;

  // bucket of a stored row, clamped to the last row
  assign st_row = ld_rdata[LdW-1 -: scc_pkg::RowW];
  assign bucket = ({1'b0, st_row} < rows_act) ? st_row
                : scc_pkg::RowW'(rows_act - scc_pkg::RowsW'(1));

  // sequencer
  always_comb begin
    state_d       = state_q;
    ent_cnt_d     = ent_cnt_q;
    sorted_d      = sorted_q;
    sorted_rows_d = sorted_rows_q;
    pkind_d       = pkind_q;
    paddr_d       = paddr_q;
    k_d           = k_q;
    r_d           = r_q;
    sum_d         = sum_q;
    bidx_d        = bidx_q;
    bslot_d       = bslot_q;
    hold_d        = hold_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    out_ptr_d     = out_ptr_q;
    out_col_d     = out_col_q;
    out_val_d     = out_val_q;
    out_stat_d    = out_stat_q;
    ld_we = 1'b0; ld_waddr = ent_cnt_q[scc_pkg::EntAw-1:0];
    ld_wdata = {ld_r, ld_c, item_i.value};
    ld_raddr = k_q[scc_pkg::EntAw-1:0];
    so_we = 1'b0; so_waddr = ns_rdata[scc_pkg::EntAw-1:0]; so_wdata = hold_q;
    so_raddr = paddr_q[scc_pkg::EntAw-1:0];
    pt_we = 1'b0; pt_waddr = r_q[scc_pkg::PtrAw-1:0]; pt_wdata = '0;
    pt_raddr = r_q[scc_pkg::PtrAw-1:0];
    ns_we = 1'b0; ns_waddr = r_q[scc_pkg::SlotAw-1:0]; ns_wdata = '0;
    ns_raddr = bucket;

    case (state_q)
      StIdle: begin
        if (take) begin
          pkind_d = item_i.kind;
          paddr_d = item_i.addr;
          case (item_i.kind)
            scc_pkg::KindLoad: begin
              out_valid_d = 1'b1; out_ptr_d = '0; out_col_d = '0; out_val_d = '0;
              if ({1'b0, ld_r} >= rows_act) begin
                out_stat_d = scc_pkg::StatRange;
              end else if (ent_cnt_q == CntW'(scc_pkg::MaxEntries)) begin
                out_stat_d = scc_pkg::StatFull;
              end else begin
                out_stat_d = scc_pkg::StatOk;
                ld_we      = 1'b1;
                ent_cnt_d  = ent_cnt_q + CntW'(1);
                sorted_d   = 1'b0;
              end
            end
            scc_pkg::KindClear: begin
              out_valid_d = 1'b1; out_ptr_d = '0; out_col_d = '0; out_val_d = '0;
              out_stat_d  = scc_pkg::StatOk;
              ent_cnt_d   = '0;
              sorted_d    = 1'b0;
            end
            default: begin
              if (sorted_q) begin
                state_d = StServe;
              end else begin
                state_d = StZero;
                r_d     = '0;
              end
            end
          endcase
        end
      end
      // clear count words 0..rows
      StZero: begin
        pt_we = 1'b1;
        r_d   = r_q + scc_pkg::RowsW'(1);
        if (r_q == rows_act) begin
          r_d = '0; k_d = '0; sum_d = '0;
          state_d = (ent_cnt_q == '0) ? StPreA : StCntA;
        end
      end
      // count entries per row
      StCntA: state_d = StCntB;
      StCntB: begin
        bidx_d   = scc_pkg::PtrAw'(bucket) + scc_pkg::PtrAw'(1);
        pt_raddr = scc_pkg::PtrAw'(bucket) + scc_pkg::PtrAw'(1);
        state_d  = StCntC;
      end
      StCntC: begin
        pt_we    = 1'b1;
        pt_waddr = bidx_q;
        pt_wdata = pt_rdata + scc_pkg::PtrW'(1);
        k_d      = k_q + CntW'(1);
        state_d  = StCntA;
        if (k_q + CntW'(1) == ent_cnt_q) begin
          k_d = '0; r_d = '0; sum_d = '0;
          state_d = StPreA;
        end
      end
      // running sum, copied into the slot memory
      StPreA: state_d = StPreB;
      StPreB: begin
        sum_d    = sum_q + pt_rdata;
        pt_we    = 1'b1;
        pt_wdata = sum_q + pt_rdata;
        ns_we    = (r_q < rows_act);
        ns_wdata = sum_q + pt_rdata;
        r_d      = r_q + scc_pkg::RowsW'(1);
        state_d  = StPreA;
        if (r_q == rows_act) begin
          k_d = '0;
          if (ent_cnt_q == '0) begin
            sorted_d = 1'b1; sorted_rows_d = rows_act; state_d = StServe;
          end else begin
            state_d = StScA;
          end
        end
      end
      // scatter each entry to its row's next slot
      StScA: state_d = StScB;
      StScB: begin
        bslot_d = bucket[scc_pkg::SlotAw-1:0];
        hold_d  = ld_rdata[SoW-1:0];
        state_d = StScC;
      end
      StScC: begin
        so_we    = 1'b1;
        ns_we    = 1'b1;
        ns_waddr = bslot_q;
        ns_wdata = ns_rdata + scc_pkg::PtrW'(1);
        k_d      = k_q + CntW'(1);
        state_d  = StScA;
        if (k_q + CntW'(1) == ent_cnt_q) begin
          sorted_d = 1'b1; sorted_rows_d = rows_act; state_d = StServe;
        end
      end
      // answer a pending read
      StServe: begin
        out_ptr_d = '0; out_col_d = '0; out_val_d = '0; out_stat_d = scc_pkg::StatOk;
        pt_raddr  = paddr_q[scc_pkg::PtrAw-1:0];
        state_d   = StIdle;
        if (pkind_q == scc_pkg::KindRdPtr) begin
          if (paddr_q > scc_pkg::PtrW'(rows_act)) begin
            out_valid_d = 1'b1; out_stat_d = scc_pkg::StatRange;
          end else if (paddr_q > scc_pkg::PtrW'(sorted_rows_q)) begin
            out_valid_d = 1'b1;
          end else begin
            state_d = StRdWt;
          end
        end else begin
          if (paddr_q >= scc_pkg::PtrW'(ent_cnt_q)) begin
            out_valid_d = 1'b1; out_stat_d = scc_pkg::StatRange;
          end else begin
            state_d = StRdWt;
          end
        end
      end
      StRdWt: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
        if (pkind_q == scc_pkg::KindRdPtr) begin
          out_ptr_d = pt_rdata;
        end else begin
          out_col_d = so_rdata[SoW-1 -: scc_pkg::ColW];
          out_val_d = so_rdata[scc_pkg::ValW-1:0];
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      num_rows_q    <= scc_pkg::RowsW'(scc_pkg::MaxRows);
      transpose_q   <= 1'b0;
      ent_cnt_q     <= '0;
      sorted_q      <= 1'b0;
      sorted_rows_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ent_cnt_q     <= ent_cnt_d;
      sorted_q      <= sorted_d;
      sorted_rows_q <= sorted_rows_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == scc_pkg::CfgNumRows) begin
        num_rows_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == scc_pkg::CfgTranspose) begin
        transpose_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pkind_q    <= pkind_d;
    paddr_q    <= paddr_d;
    k_q        <= k_d;
    r_q        <= r_d;
    sum_q      <= sum_d;
    bidx_q     <= bidx_d;
    bslot_q    <= bslot_d;
    hold_q     <= hold_d;
    out_ptr_q  <= out_ptr_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pointer   = out_ptr_q;
  assign result_o.out_col   = out_col_q;
  assign result_o.out_value = out_val_q;
  assign result_o.status    = out_stat_q;

  // store never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_cnt_q <= CntW'(scc_pkg::MaxEntries))
    else $error("entry count beyond store depth");

  // no new request while a read or sort is in progress
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !item_i.ready)
    else $error("request taken while busy");

  // memory read always ends in a result
  a_rd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRdWt |=> out_valid_q)
    else $error("read produced no result");

  // sorted flag only set at the end of a sort
  a_sort_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sorted_q) |-> ($past(state_q) == StScC || $past(state_q) == StPreB))
    else $error("sorted flag set outside sort");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [scc_pkg::PtrW-1:0]  pointer;
    logic [scc_pkg::ColW-1:0]  out_col;
    logic [scc_pkg::ValW-1:0]  out_value;
    logic [scc_pkg::StatW-1:0] status;
  } csr_word_t;

  // reference copy of the converter state, predicts one result per transfer
  class csr_scoreboard;
    logic [scc_pkg::RowW-1:0]  ld_row [scc_pkg::MaxEntries];
    logic [scc_pkg::ColW-1:0]  ld_col [scc_pkg::MaxEntries];
    logic [scc_pkg::ValW-1:0]  ld_val [scc_pkg::MaxEntries];
    logic [scc_pkg::ColW-1:0]  st_col [scc_pkg::MaxEntries];
    logic [scc_pkg::ValW-1:0]  st_val [scc_pkg::MaxEntries];
    int unsigned      row_ptr [scc_pkg::MaxRows+1];
    int unsigned      n_ent;
    bit               is_ordered;
    int unsigned      rows_cfg;
    bit               swap;
    csr_word_t        due_q [$];
    int               errors;

    function new();
      rows_cfg   = scc_pkg::MaxRows;
      swap       = 1'b0;
      n_ent      = 0;
      is_ordered = 1'b0;
      errors     = 0;
      foreach (row_ptr[i]) row_ptr[i] = 0;
    endfunction

    function int unsigned rows_eff();
      if (rows_cfg == 0) return 1;
      if (rows_cfg > scc_pkg::MaxRows) return scc_pkg::MaxRows;
      return rows_cfg;
    endfunction

    // counting sort by row, rows past the count fall into the last row
    function void order_by_row();
      int unsigned rows, b, total, pos;
      int unsigned slot [scc_pkg::MaxRows];
      rows = rows_eff();
      foreach (row_ptr[i]) row_ptr[i] = 0;
      for (int k = 0; k < n_ent; k++) begin
        b = (ld_row[k] < rows) ? ld_row[k] : rows - 1;
        row_ptr[b+1]++;
      end
      total = 0;
      for (int r = 0; r <= rows; r++) begin
        total += row_ptr[r];
        row_ptr[r] = total;
      end
      for (int r = 0; r < rows; r++) slot[r] = row_ptr[r];
      for (int k = 0; k < n_ent; k++) begin
        b = (ld_row[k] < rows) ? ld_row[k] : rows - 1;
        pos = slot[b];
        slot[b]++;
        st_col[pos] = ld_col[k];
        st_val[pos] = ld_val[k];
      end
      is_ordered = 1'b1;
    endfunction

    function void note_item(logic [scc_pkg::KindW-1:0] kind, logic [scc_pkg::RowW-1:0] row,
                            logic [scc_pkg::ColW-1:0] col, logic [scc_pkg::ValW-1:0] val,
                            logic [scc_pkg::PtrW-1:0] addr);
      csr_word_t  w;
      logic [scc_pkg::RowW-1:0] r;
      logic [scc_pkg::ColW-1:0] c;
      w = '0;
      case (kind)
        scc_pkg::KindLoad: begin
          r = swap ? col : row;
          c = swap ? row : col;
          if (r >= rows_eff()) w.status = scc_pkg::StatRange;
          else if (n_ent >= scc_pkg::MaxEntries) w.status = scc_pkg::StatFull;
          else begin
            ld_row[n_ent] = r;
            ld_col[n_ent] = c;
            ld_val[n_ent] = val;
            n_ent++;
            is_ordered = 1'b0;
          end
        end
        scc_pkg::KindRdPtr: begin
          if (!is_ordered) order_by_row();
          if (addr > rows_eff()) w.status = scc_pkg::StatRange;
          else w.pointer = scc_pkg::PtrW'(row_ptr[addr]);
        end
        scc_pkg::KindRdEnt: begin
          if (!is_ordered) order_by_row();
          if (addr >= n_ent) w.status = scc_pkg::StatRange;
          else begin
            w.out_col   = st_col[addr];
            w.out_value = st_val[addr];
          end
        end
        default: begin
          n_ent      = 0;
          is_ordered = 1'b0;
        end
      endcase
      due_q.push_back(w);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(csr_word_t got);
      csr_word_t want;
      if (due_q.size() == 0) begin
        report_mismatch("result with no request outstanding", 64'(got.status), 64'(0));
      end else begin
        want = due_q.pop_front();
        if (got.pointer !== want.pointer)
          report_mismatch("pointer", 64'(got.pointer), 64'(want.pointer));
        if (got.out_col !== want.out_col)
          report_mismatch("out_col", 64'(got.out_col), 64'(want.out_col));
        if (got.out_value !== want.out_value)
          report_mismatch("out_value", got.out_value, want.out_value);
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [scc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [scc_pkg::CfgDataW-1:0] cfg_data;
  int unsigned         tx_idle;
  int unsigned         rx_idle;
  int unsigned         sent;
  int unsigned         stuck_cycles;
  csr_scoreboard       sb;

  scc_item_if item_if ();
  scc_res_if  res_if ();

  sparse_coo_to_csr_converter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni && item_if.valid && item_if.ready) begin
      sb.note_item(item_if.kind, item_if.row, item_if.col, item_if.value, item_if.addr);
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result({res_if.pointer, res_if.out_col, res_if.out_value, res_if.status});
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= 150000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task send_item(logic [scc_pkg::KindW-1:0] kind, logic [scc_pkg::RowW-1:0] row,
                 logic [scc_pkg::ColW-1:0] col, logic [scc_pkg::ValW-1:0] val,
                 logic [scc_pkg::PtrW-1:0] addr);
    while ($urandom_range(99) < tx_idle) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.kind  <= kind;
    item_if.row   <= row;
    item_if.col   <= col;
    item_if.value <= val;
    item_if.addr  <= addr;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // both registers written back to back while idle
  task write_regs(int unsigned rows, bit swap);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= scc_pkg::CfgNumRows;
    cfg_data <= rows[scc_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_idx  <= scc_pkg::CfgTranspose;
    cfg_data <= {{(scc_pkg::CfgDataW-1){1'b0}}, swap};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.rows_cfg = 32'(rows[scc_pkg::CfgDataW-1:0]);
    sb.swap     = swap;
    @(posedge clk_i);
  endtask

  function logic [scc_pkg::ValW-1:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  task load(int unsigned row, int unsigned col, logic [scc_pkg::ValW-1:0] val);
    send_item(scc_pkg::KindLoad, row[scc_pkg::RowW-1:0], col[scc_pkg::ColW-1:0], val,
              scc_pkg::PtrW'($urandom));
  endtask

  task rd(logic [scc_pkg::KindW-1:0] kind, int unsigned addr);
    send_item(kind, scc_pkg::RowW'($urandom), scc_pkg::ColW'($urandom), rand_val(),
              addr[scc_pkg::PtrW-1:0]);
  endtask

  // row index for a load: mostly inside the row count, sometimes anything
  function int unsigned pick_row();
    if ($urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(sb.rows_eff() - 1);
  endfunction

  // one matrix: configure, clear, load, optionally shrink, then read back
  task matrix_round();
    int unsigned rows, n, m, r;
    case ($urandom_range(11))
      0:       rows = 0;
      1:       rows = 2047;
      2:       rows = scc_pkg::MaxRows;
      3:       rows = $urandom_range(1, scc_pkg::MaxRows);
      default: rows = $urandom_range(1, 16);
    endcase
    write_regs(rows, 1'($urandom_range(1)));
    send_item(scc_pkg::KindClear, scc_pkg::RowW'($urandom), scc_pkg::ColW'($urandom),
              rand_val(), scc_pkg::PtrW'($urandom));
    n = $urandom_range(24);
    for (int i = 0; i < n; i++) begin
      r = pick_row();
      if (sb.swap) load($urandom_range(1023), r, rand_val());
      else load(r, $urandom_range(1023), rand_val());
    end
    if ($urandom_range(3) == 0) write_regs($urandom_range(1, sb.rows_eff()), sb.swap);
    m = $urandom_range(4, 18);
    for (int i = 0; i < m; i++) begin
      case ($urandom_range(15))
        0:       rd(scc_pkg::KindRdPtr, $urandom_range(8191));
        1:       rd(scc_pkg::KindRdEnt, $urandom_range(8191));
        2:       load(pick_row(), $urandom_range(1023), rand_val());
        3, 4, 5, 6, 7, 8: rd(scc_pkg::KindRdPtr, $urandom_range(sb.rows_eff() + 1));
        default: rd(scc_pkg::KindRdEnt, $urandom_range(sb.n_ent + 1));
      endcase
    end
    // row count moved after the sort
    if ($urandom_range(5) == 0) begin
      write_regs($urandom_range(2047), sb.swap);
      for (int i = 0; i < 4; i++) rd(scc_pkg::KindRdPtr, $urandom_range(sb.rows_eff() + 1));
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = scc_pkg::CfgNumRows;
    cfg_data      = '0;
    item_if.valid = 1'b0;
    item_if.kind  = scc_pkg::KindClear;
    item_if.row   = '0;
    item_if.col   = '0;
    item_if.value = '0;
    item_if.addr  = '0;
    res_if.ready  = 1'b0;
    tx_idle       = 7;
    rx_idle       = 88;
    sent          = 0;
    stuck_cycles  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, stable order, range checks
    write_regs(4, 1'b0);
    send_item(scc_pkg::KindClear, '0, '0, '0, '0);
    load(3, 1023, '1);
    load(0, 0, '0);
    load(4, 9, rand_val());
    load(1, 5, rand_val());
    load(3, 7, rand_val());
    for (int i = 0; i <= 5; i++) rd(scc_pkg::KindRdPtr, i);
    for (int i = 0; i <= 4; i++) rd(scc_pkg::KindRdEnt, i);
    rd(scc_pkg::KindRdEnt, 8191);
    // zero rows acts as one, with swap
    write_regs(0, 1'b1);
    send_item(scc_pkg::KindClear, '1, '1, '1, '1);
    load(5, 0, rand_val());
    load(5, 1, rand_val());
    rd(scc_pkg::KindRdPtr, 1);
    rd(scc_pkg::KindRdPtr, 2);
    rd(scc_pkg::KindRdEnt, 0);
    // rows lowered after load fold into the last row
    write_regs(8, 1'b0);
    load(7, 3, rand_val());
    load(2, 4, rand_val());
    write_regs(2, 1'b0);
    rd(scc_pkg::KindRdPtr, 2);
    rd(scc_pkg::KindRdEnt, 0);
    rd(scc_pkg::KindRdEnt, 2);
    write_regs(2047, 1'b0);
    rd(scc_pkg::KindRdPtr, 1024);
    rd(scc_pkg::KindRdPtr, 1025);

    // random rounds under three backpressure mixes
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 7 : (phase == 1) ? 88 : 0;
      rx_idle = (phase == 0) ? 88 : (phase == 1) ? 7 : 0;
      while (sent < 30 + 300 * (phase + 1)) matrix_round();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
